// File: rtl/assert_macros.svh
// assertion macros used by pressure_to_depth_compensation
// expects clk and rst_n in the scope of the use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked outside reset
`define PDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, checked outside reset
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptd_comp_pkg.sv
// constants and types for the pressure to depth compensation block
// no dependencies
`default_nettype none

package ptd_comp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned AMB_W      = 22;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned DEPTH_W    = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TCS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TCO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TREF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd5;

  localparam logic [AMB_W-1:0] AMBIENT_RESET = 22'd101260;

  // 100 times the q0.32 reciprocal of 9.81 * 997 (439132)
  localparam int unsigned       SCALE_W     = 26;
  localparam logic [SCALE_W-1:0] DEPTH_SCALE = 26'd43913200;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] off;
    logic [CAL_W-1:0] tcs;
    logic [CAL_W-1:0] tco;
    logic [CAL_W-1:0] tref;
    logic [AMB_W-1:0] ambient;
  } cal_t;

endpackage

`default_nettype wire

// File: rtl/pressure_to_depth_compensation.sv
// pressure to depth compensation: raw pressure/temperature pair to depth in cm
// depends on ptd_comp_pkg and assert_macros.svh
//
//  channel | direction | beat contents (lowest bit first)
//  in_     | slave     | pressure_raw[23:0], temperature_raw[47:24]
//  out_    | master    | depth_cm[31:0], signed
//  cfg_    | write     | index 0..5, data 22 bit
//
// one beat per cycle sustained while the output is not stalled
// each beat passes through the eleven register stages of the multiply and rounding path
// every stage holds its own valid bit and advances when the next one is free
// a stalled output holds only the stages behind it that are full
// rst_n clears the valid bits and loads the register reset values
`default_nettype none
`include "assert_macros.svh"

module pressure_to_depth_compensation (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [47:0]                         in_tdata,  // pressure_raw, temperature_raw
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [31:0]                              out_tdata, // depth_cm
  input  wire logic                                cfg_we,
  input  wire logic [ptd_comp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [ptd_comp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned NSTG = 11;

  ptd_comp_pkg::cal_t cal_r;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] stg_en;
  logic [NSTG-1:0] held;
  logic [8:0]      depth_hi;

  // stage data
  logic        [23:0] d1_s0_r, d1_s1_r, d1_s2_r;
  logic signed [24:0] dt_r, dt_nxt;
  logic signed [41:0] tsp_r, tsp_nxt, tcp_r, tcp_nxt;
  logic signed [33:0] sens_r, sens_nxt;
  logic signed [34:0] off_s2_r, off_s3_r, off_s4_r, off_s5_r, off_nxt;
  logic        [40:0] pp_lo_r, pp_lo_nxt;
  logic signed [41:0] pp_hi_r, pp_hi_nxt;
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [36:0] q1_r, q1_nxt;
  logic signed [37:0] diff_r, diff_nxt;
  logic signed [28:0] p_r, p_nxt;
  logic        [29:0] mag_r, mag_nxt;
  logic               neg_s8_r, neg_s9_r, neg_nxt;
  logic        [55:0] scl_r, scl_nxt;
  logic        [31:0] depth_r, depth_nxt;

  logic signed [41:0] ts_rnd, tc_rnd;
  logic signed [57:0] prod_rnd;
  logic signed [37:0] diff_rnd;
  logic signed [24:0] q2;
  logic signed [29:0] x_sub;
  logic        [23:0] q3;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.sens    <= '0;
      cal_r.off     <= '0;
      cal_r.tcs     <= '0;
      cal_r.tco     <= '0;
      cal_r.tref    <= '0;
      cal_r.ambient <= ptd_comp_pkg::AMBIENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptd_comp_pkg::CFG_SENS:    cal_r.sens    <= cfg_wdata[15:0];
        ptd_comp_pkg::CFG_OFF:     cal_r.off     <= cfg_wdata[15:0];
        ptd_comp_pkg::CFG_TCS:     cal_r.tcs     <= cfg_wdata[15:0];
        ptd_comp_pkg::CFG_TCO:     cal_r.tco     <= cfg_wdata[15:0];
        ptd_comp_pkg::CFG_TREF:    cal_r.tref    <= cfg_wdata[15:0];
        ptd_comp_pkg::CFG_AMBIENT: cal_r.ambient <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    stg_en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !v_r[k] || stg_en[k+1];
    end
  end

  assign in_tready  = stg_en[0];
  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = depth_r;
  assign held       = v_r & ~stg_en;
  assign depth_hi   = out_tdata[31:23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stg_en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // datapath
  always_comb begin
    // temperature difference
    dt_nxt = $signed({1'b0, in_tdata[47:24]}) - $signed({1'b0, cal_r.tref, 8'b0});
    // temperature terms
    tsp_nxt = $signed({26'b0, cal_r.tcs}) * 42'(dt_r);
    tcp_nxt = $signed({26'b0, cal_r.tco}) * 42'(dt_r);
    // sens and offset, shifts rounded toward zero
    ts_rnd   = tsp_r + (tsp_r[41] ? 42'sd255 : 42'sd0);
    tc_rnd   = tcp_r + (tcp_r[41] ? 42'sd127 : 42'sd0);
    sens_nxt = $signed({3'b0, cal_r.sens, 15'b0}) + $signed(ts_rnd[41:8]);
    off_nxt  = $signed({3'b0, cal_r.off, 16'b0}) + $signed(tc_rnd[41:7]);
    // pressure times sens in two partial products
    pp_lo_nxt = {17'b0, d1_s2_r} * {24'b0, sens_r[16:0]};
    pp_hi_nxt = $signed({18'b0, d1_s2_r}) * 42'($signed(sens_r[33:17]));
    prod_nxt  = $signed({pp_hi_r[40:0], 17'b0} + {17'b0, pp_lo_r});
    // first scale down
    prod_rnd = prod_r + (prod_r[57] ? 58'sd2097151 : 58'sd0);
    q1_nxt   = $signed(prod_rnd[57:21]);
    diff_nxt = $signed({q1_r[36], q1_r}) - $signed({{3{off_s5_r[34]}}, off_s5_r});
    // pascal
    diff_rnd = diff_r + (diff_r[37] ? 38'sd8191 : 38'sd0);
    q2       = $signed(diff_rnd[37:13]);
    p_nxt    = $signed({q2[24], q2, 3'b0}) + $signed({{3{q2[24]}}, q2, 1'b0});
    // gauge pressure as sign and magnitude
    x_sub    = $signed({p_r[28], p_r}) - $signed({8'b0, cal_r.ambient});
    neg_nxt  = x_sub[29];
    mag_nxt  = x_sub[29] ? 30'(-x_sub) : 30'(x_sub);
    // depth scale
    scl_nxt   = {26'b0, mag_r} * {30'b0, ptd_comp_pkg::DEPTH_SCALE};
    q3        = scl_r[55:32];
    depth_nxt = neg_s9_r ? -{8'b0, q3} : {8'b0, q3};
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      dt_r    <= dt_nxt;
      d1_s0_r <= in_tdata[23:0];
    end
    if (stg_en[1]) begin
      tsp_r   <= tsp_nxt;
      tcp_r   <= tcp_nxt;
      d1_s1_r <= d1_s0_r;
    end
    if (stg_en[2]) begin
      sens_r   <= sens_nxt;
      off_s2_r <= off_nxt;
      d1_s2_r  <= d1_s1_r;
    end
    if (stg_en[3]) begin
      pp_lo_r  <= pp_lo_nxt;
      pp_hi_r  <= pp_hi_nxt;
      off_s3_r <= off_s2_r;
    end
    if (stg_en[4]) begin
      prod_r   <= prod_nxt;
      off_s4_r <= off_s3_r;
    end
    if (stg_en[5]) begin
      q1_r     <= q1_nxt;
      off_s5_r <= off_s4_r;
    end
    if (stg_en[6]) begin
      diff_r <= diff_nxt;
    end
    if (stg_en[7]) begin
      p_r <= p_nxt;
    end
    if (stg_en[8]) begin
      mag_r    <= mag_nxt;
      neg_s8_r <= neg_nxt;
    end
    if (stg_en[9]) begin
      scl_r    <= scl_nxt;
      neg_s9_r <= neg_s8_r;
    end
    if (stg_en[10]) begin
      depth_r <= depth_nxt;
    end
  end

  // checks
  `PDC_ASSERT_NEXT(a_in_beat_lands, in_tvalid && in_tready, v_r[0], "beat not in first stage")
  `PDC_ASSERT_SAME(a_full_when_stalled, !in_tready, &v_r, "input stalled with a free stage")
  `PDC_ASSERT_NEXT(a_held_stage_kept, |held, (v_r & $past(held)) == $past(held), "held beat lost")
  `PDC_ASSERT_SAME(a_depth_range, out_tvalid, (depth_hi == '0) || (&depth_hi), "depth out of range")

endmodule

`default_nettype wire

// File: dv/pressure_to_depth_compensation_test.sv
`timescale 1ns / 100ps
// testbench for pressure_to_depth_compensation: a directed table, then random calibration phases
// each untyped depth is predicted from the raw pair and a shadow of the calibration registers
// depends on ptd_comp_pkg and the rtl top level

module pressure_to_depth_compensation_test;

  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned BEATS_PER_PHASE = 150;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned RESET_CYCLES    = 12;

  typedef logic [ptd_comp_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [ptd_comp_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [ptd_comp_pkg::RAW_W-1:0]      raw_t;
  typedef logic [ptd_comp_pkg::DEPTH_W-1:0]    depth_t;

  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

  localparam longint unsigned RECIP_Q32 = 64'd439132;
  localparam longint DEPTH_MAX = 64'sh7FFF_FFFF;
  localparam longint DEPTH_MIN = -64'sh8000_0000;

  localparam depth_t DEPTH_AT_RESET = -32'sd1035;
  localparam depth_t DEPTH_ZERO     = 32'd0;
  localparam logic [ptd_comp_pkg::CAL_W-1:0] CAL_MAX = '1;
  localparam logic [ptd_comp_pkg::AMB_W-1:0] AMB_MAX = '1;
  localparam raw_t RAW_MAX = '1;

  localparam cfg_idx_t CAL_REGS [5] = '{ptd_comp_pkg::CFG_SENS, ptd_comp_pkg::CFG_OFF,
                                        ptd_comp_pkg::CFG_TCS, ptd_comp_pkg::CFG_TCO,
                                        ptd_comp_pkg::CFG_TREF};

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t  addr;
    cfg_data_t value;
    raw_t      p_raw;
    raw_t      t_raw;
    logic      typed;
    depth_t    depth;
  } row_t;

  localparam int unsigned N_ROWS = 31;

  row_t directed_rows [N_ROWS] = '{
    // calibration at reset: every pair reads the ambient offset alone
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h000000, 24'h000000, 1'b1, DEPTH_AT_RESET},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, DEPTH_AT_RESET},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'hFFFFFF, 24'h000000, 1'b1, DEPTH_AT_RESET},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h000000, 24'hFFFFFF, 1'b1, DEPTH_AT_RESET},
    '{ROW_REG,  ptd_comp_pkg::CFG_AMBIENT, 22'd0, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h800000, 24'h123456, 1'b1, DEPTH_ZERO},
    // typical calibration
    '{ROW_REG,  ptd_comp_pkg::CFG_SENS, 22'd40000, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_OFF,  22'd36000, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TCS,  22'd23000, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TCO,  22'd21000, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TREF, 22'd33000, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_AMBIENT, 22'd101260, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'd6000000, 24'd8448000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'd6000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'd6000000, 24'hFFFFFF, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h000000, 24'd8448000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'hFFFFFF, 24'd8448000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'd5000000, 24'd8000000, 1'b0, DEPTH_ZERO},
    // every register at its top
    '{ROW_REG,  ptd_comp_pkg::CFG_SENS, 22'h00FFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_OFF,  22'h00FFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TCS,  22'h00FFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TCO,  22'h00FFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_TREF, 22'h00FFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  ptd_comp_pkg::CFG_AMBIENT, 22'h3FFFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'hFFFFFF, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h000000, 24'hFFFFFF, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    // writes to unmapped indexes change nothing
    '{ROW_REG,  CFG_SPARE_6, 22'h3FFFFF, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_REG,  CFG_SPARE_7, 22'h155555, 24'h000000, 24'h000000, 1'b0, DEPTH_ZERO},
    '{ROW_BEAT, ptd_comp_pkg::CFG_SENS, 22'd0, 24'h800000, 24'h7FFFFF, 1'b0, DEPTH_ZERO}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // pressure_raw, temperature_raw
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // depth_cm
  logic        cfg_we     = 1'b0;
  cfg_idx_t    cfg_addr   = '0;
  cfg_data_t   cfg_wdata  = '0;

  ptd_comp_pkg::cal_t cal_shadow;
  depth_t             depth_expected [$];
  depth_t             depth_want;
  logic               beat_typed = 1'b0;
  depth_t             beat_depth = '0;
  int unsigned        errors     = 0;
  int unsigned        cycles     = 0;
  int unsigned        burst_left = 0;
  sink_mode_t         sink_mode  = SINK_OPEN;
  int unsigned        sink_left  = 0;
  int unsigned        sink_tick  = 0;

  pressure_to_depth_compensation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic depth_t depth_from_raw(input raw_t p_raw, input raw_t t_raw);
    longint          d_t, sens, offs, pa, x, q;
    longint unsigned mag;
    d_t  = longint'(t_raw) - longint'(cal_shadow.tref) * 256;
    sens = longint'(cal_shadow.sens) * 32768 + (longint'(cal_shadow.tcs) * d_t) / 256;
    offs = longint'(cal_shadow.off) * 65536 + (longint'(cal_shadow.tco) * d_t) / 128;
    pa   = (((longint'(p_raw) * sens) / 2097152 - offs) / 8192) * 10;
    x    = (pa - longint'(cal_shadow.ambient)) * 100;
    mag  = (x < 0) ? longint'(-x) : x;
    q    = longint'((mag * RECIP_Q32) >> 32);
    if (x < 0) q = -q;
    if (q > DEPTH_MAX) q = DEPTH_MAX;
    if (q < DEPTH_MIN) q = DEPTH_MIN;
    return q[ptd_comp_pkg::DEPTH_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_shadow = '0;
      cal_shadow.ambient = ptd_comp_pkg::AMBIENT_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        if (depth_expected.size() == 0) begin
          errors++;
          $display("%0t: depth_cm expected none got %0d", $time, $signed(out_tdata));
        end else begin
          depth_want = depth_expected.pop_front();
          if (out_tdata !== depth_want) begin
            errors++;
            $display("%0t: depth_cm expected %0d got %0d", $time,
                     $signed(depth_want), $signed(out_tdata));
          end
        end
      end
      if (in_tvalid && in_tready)
        depth_expected.push_back(beat_typed ? beat_depth
                                            : depth_from_raw(in_tdata[23:0], in_tdata[47:24]));
      if (cfg_we) begin
        case (cfg_addr)
          ptd_comp_pkg::CFG_SENS:    cal_shadow.sens    = cfg_wdata[ptd_comp_pkg::CAL_W-1:0];
          ptd_comp_pkg::CFG_OFF:     cal_shadow.off     = cfg_wdata[ptd_comp_pkg::CAL_W-1:0];
          ptd_comp_pkg::CFG_TCS:     cal_shadow.tcs     = cfg_wdata[ptd_comp_pkg::CAL_W-1:0];
          ptd_comp_pkg::CFG_TCO:     cal_shadow.tco     = cfg_wdata[ptd_comp_pkg::CAL_W-1:0];
          ptd_comp_pkg::CFG_TREF:    cal_shadow.tref    = cfg_wdata[ptd_comp_pkg::CAL_W-1:0];
          ptd_comp_pkg::CFG_AMBIENT: cal_shadow.ambient = cfg_wdata[ptd_comp_pkg::AMB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d depths outstanding", $time, depth_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls follow their own mode sequence
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 200);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:     out_tready <= 1'b1;
      SINK_RANDOM:   out_tready <= ($urandom_range(0, 1) == 1);
      SINK_SPARSE:   out_tready <= ($urandom_range(0, 5) == 0);
      SINK_PERIODIC: out_tready <= (sink_tick % 3 == 0);
      default:       out_tready <= 1'b1;
    endcase
  end

  // called at a falling edge, returns at a falling edge with the pipeline empty
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    in_tvalid <= 1'b0;
    while (depth_expected.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_beat(input raw_t p_raw, input raw_t t_raw,
                           input logic typed, input depth_t depth);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 32);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {t_raw, p_raw};
    beat_typed <= typed;
    beat_depth <= depth;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  initial begin : stimulus
    int unsigned ph, n, shape;
    cfg_data_t   v;
    raw_t        p_raw, t_raw;
    longint      centre;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      else
        push_beat(directed_rows[i].p_raw, directed_rows[i].t_raw,
                  directed_rows[i].typed, directed_rows[i].depth);
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      // typical, fully random and extreme calibration in turn
      shape = ph % 3;
      foreach (CAL_REGS[r]) begin
        case (shape)
          0:       v = cfg_data_t'($urandom_range(20000, 50000));
          1:       v = cfg_data_t'($urandom_range(0, CAL_MAX));
          default: v = $urandom_range(0, 1) ? cfg_data_t'(CAL_MAX) : '0;
        endcase
        write_reg(CAL_REGS[r], v);
      end
      case (shape)
        0:       v = cfg_data_t'($urandom_range(90000, 110000));
        1:       v = cfg_data_t'($urandom_range(0, AMB_MAX));
        default: v = $urandom_range(0, 1) ? cfg_data_t'(AMB_MAX) : '0;
      endcase
      write_reg(ptd_comp_pkg::CFG_AMBIENT, v);
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                  cfg_data_t'($urandom_range(0, AMB_MAX)));

      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          p_raw = $urandom_range(0, 1) ? RAW_MAX : '0;
          t_raw = $urandom_range(0, 1) ? RAW_MAX : '0;
        end else if (shape < 4) begin
          p_raw = raw_t'($urandom_range(0, RAW_MAX));
          t_raw = raw_t'($urandom_range(0, RAW_MAX));
        end else begin
          // temperature near the reference reading, either side
          p_raw  = raw_t'($urandom_range(1000000, 12000000));
          centre = longint'(cal_shadow.tref) * 256
                   + longint'($urandom_range(0, 2097152)) - 1048576;
          if (centre < 0) centre = 0;
          if (centre > longint'(RAW_MAX)) centre = longint'(RAW_MAX);
          t_raw = centre[ptd_comp_pkg::RAW_W-1:0];
        end
        push_beat(p_raw, t_raw, 1'b0, DEPTH_ZERO);
      end
    end

    in_tvalid <= 1'b0;
    while (depth_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
